// File: rtl/btw_pkg.sv
// Package for the balanced-ternary weight core: widths, power-of-three
// constants and the token and beat structs shared by the cell row and the top.
`timescale 1ns / 1ps
`default_nettype none

package btw_pkg;

    localparam int NUM_TRITS = 22;
    localparam int VALUE_W   = 34;
    localparam int WEIGHT_W  = 34;
    localparam int TDATA_W   = ((VALUE_W + 7) / 8) * 8;
    localparam int MDATA_W   = ((WEIGHT_W + 7) / 8) * 8;
    localparam int TUSER_W   = 2;

    // 3^k, elaboration-time only
    function automatic logic [63:0] pow3(input int k);
        logic [63:0] p;
        p = 64'd1;
        for (int i = 0; i < k; i++) begin
            p = p * 64'd3;
        end
        return p;
    endfunction

    // 3^0 + .. + 3^k, zero for k < 0
    function automatic logic [63:0] sum3(input int k);
        logic [63:0] s;
        s = 64'd0;
        for (int i = 0; i <= k; i++) begin
            s = s + pow3(i);
        end
        return s;
    endfunction

    localparam logic [63:0] FULL_SUM64 = sum3(NUM_TRITS - 1);
    localparam int SUM_BITS = $clog2(FULL_SUM64 + 64'd1);
    // width of per-cell constants and of compares against them
    localparam int CW = (SUM_BITS > VALUE_W) ? SUM_BITS : VALUE_W;
    localparam logic [CW-1:0] FULL_SUM = CW'(FULL_SUM64);

    typedef struct packed {
        logic               valid;
        logic               err;
        logic               left;
        logic [VALUE_W-1:0] r;
    } token_t;

    typedef struct packed {
        logic                valid;
        logic [WEIGHT_W-1:0] weight;
        logic                left;
        logic                last;
        logic                oor;
    } beat_t;

endpackage

`default_nettype wire

// File: rtl/btw_cell.sv
// One trit position of the balanced-ternary row. Holds a token, places 3^k
// when the remainder needs it, hands the token on. Depends on btw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module btw_cell (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  en,
    input  wire logic [btw_pkg::CW-1:0] power_i,  // 3^k
    input  wire logic [btw_pkg::CW-1:0] below_i,  // 3^0 + .. + 3^(k-1)
    input  btw_pkg::token_t            tok_i,
    output btw_pkg::token_t            tok_o,
    output btw_pkg::beat_t             beat_o,
    output logic                       busy_o
);
    import btw_pkg::*;

    token_t             tok_reg;
    token_t             tok_next;
    logic [CW-1:0]      r_ext;
    logic [CW-1:0]      diff;
    logic               flip;
    logic               hit;
    logic [VALUE_W-1:0] r_new;

    always_comb begin
        tok_next = en ? tok_i : tok_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg.valid <= 1'b0;
        end else begin
            tok_reg.valid <= tok_next.valid;
        end
        tok_reg.err  <= tok_next.err;
        tok_reg.left <= tok_next.left;
        tok_reg.r    <= tok_next.r;
    end

    // remainder never exceeds 3^0+..+3^k here; it needs 3^k once above the lower sum
    always_comb begin
        r_ext = CW'(tok_reg.r);
        hit   = tok_reg.valid && (tok_reg.err || (r_ext > below_i));
        if (r_ext >= power_i) begin
            diff = r_ext - power_i;
            flip = 1'b0;
        end else begin
            diff = power_i - r_ext;
            flip = 1'b1;
        end
        r_new = hit ? diff[VALUE_W-1:0] : tok_reg.r;
    end

    always_comb begin
        beat_o.valid  = hit;
        beat_o.weight = tok_reg.err ? '0 : power_i[WEIGHT_W-1:0];
        beat_o.left   = tok_reg.left;
        beat_o.last   = tok_reg.err || (r_new == '0);
        beat_o.oor    = tok_reg.err;

        tok_o.valid = tok_reg.valid && !tok_reg.err && (r_new != '0);
        tok_o.err   = 1'b0;
        tok_o.left  = (hit && flip) ? !tok_reg.left : tok_reg.left;
        tok_o.r     = r_new;
    end

    assign busy_o = tok_reg.valid;

endmodule

`default_nettype wire

// File: rtl/balanced_ternary_weights_core.sv
// Top level of the balanced-ternary weight core: stream ports, the row of
// btw_cell stages and the output register. Depends on btw_pkg and btw_cell.
`timescale 1ns / 1ps
`default_nettype none

// Breaks each input value into power-of-three weights, largest first, each
// tagged with its pan (right pan first, switching whenever a weight overshoots
// the remainder). A row of NUM_TRITS cells, one per power 3^k from the top
// down, passes the remainder along one cell per cycle; a cell emits one beat
// when the remainder needs its power. Only one value is in the row at a time:
// s_tready is high when the row is empty and the output register can load.
// An item walks down the row from the top cell, then enters the output
// register; the row frees as soon as the final weight is placed, and output
// stalls freeze the whole row. A zero value is taken and gives no beat. A
// value above (3^NUM_TRITS-1)/2 gives a single beat with weight 0, tlast set
// and the out-of-range flag set.
module balanced_ternary_weights_core (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    // input stream
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    input  wire logic [btw_pkg::TDATA_W-1:0] s_tdata,   // [33:0] value
    // result stream
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    output logic [btw_pkg::MDATA_W-1:0]     m_tdata,    // [33:0] weight
    output logic [btw_pkg::TUSER_W-1:0]     m_tuser,    // [0] on_left_pan, [1] out_of_range
    output logic                            m_tlast     // last weight of this value
);
    import btw_pkg::*;

    token_t               tok_in;
    token_t               tok_out [NUM_TRITS];
    beat_t                beats   [NUM_TRITS];
    logic [NUM_TRITS-1:0] cell_busy;
    logic [NUM_TRITS-1:0] cell_emit;
    beat_t                beat_any;
    logic                 out_free;
    logic                 in_beat;
    logic [VALUE_W-1:0]   value;

    logic                 m_valid_reg;
    logic                 m_valid_next;
    logic [WEIGHT_W-1:0]  weight_reg;
    logic                 left_reg;
    logic                 last_reg;
    logic                 oor_reg;

    // output register frees when empty or being taken; the row moves with it
    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (cell_busy == '0) && out_free;
    assign in_beat  = s_tvalid && s_tready;
    assign value    = s_tdata[VALUE_W-1:0];

    // new token enters the top cell; error tokens report from there at once
    always_comb begin
        tok_in.valid = in_beat && (value != '0);
        tok_in.err   = CW'(value) > FULL_SUM;
        tok_in.left  = 1'b0;
        tok_in.r     = value;
    end

    for (genvar k = 0; k < NUM_TRITS; k++) begin : g_cell
        localparam logic [CW-1:0] POWER = CW'(pow3(k));
        localparam logic [CW-1:0] BELOW = CW'(sum3(k - 1));

        btw_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (out_free),
            .power_i (POWER),
            .below_i (BELOW),
            .tok_i   ((k == NUM_TRITS - 1) ? tok_in : tok_out[(k + 1) % NUM_TRITS]),
            .tok_o   (tok_out[k]),
            .beat_o  (beats[k]),
            .busy_o  (cell_busy[k])
        );

        assign cell_emit[k] = beats[k].valid;
    end

    // a single token means at most one cell emits per cycle
    always_comb begin
        beat_any = '0;
        for (int k = 0; k < NUM_TRITS; k++) begin
            if (beats[k].valid) begin
                beat_any = beat_any | beats[k];
            end
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_free) begin
            m_valid_next = beat_any.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        if (out_free && beat_any.valid) begin
            weight_reg <= beat_any.weight;
            left_reg   <= beat_any.left;
            last_reg   <= beat_any.last;
            oor_reg    <= beat_any.oor;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = MDATA_W'(weight_reg);
    assign m_tuser  = {oor_reg, left_reg};
    assign m_tlast  = last_reg;

    // one value in the row at most
    a_one_token: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(cell_busy))
        else $error("more than one token in the cell row");

    a_one_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(cell_emit))
        else $error("several cells emitting in one cycle");

    // an error beat is always alone and carries no weight
    a_err_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && oor_reg) |-> (last_reg && (weight_reg == '0)))
        else $error("out-of-range beat malformed");

    // a stalled row must not lose its token
    a_row_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (!out_free && (cell_busy != '0)) |=> (cell_busy != '0))
        else $error("token lost while output stalled");

endmodule

`default_nettype wire
